// ----- sv/rot90_pkg.sv -----
package rot90_pkg;

  localparam int DEF_MAX_DIM    = 256;
  localparam int DEF_PIXEL_BITS = 24;
  localparam int DIM_RESET      = 256;

  // configuration port
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // per-beat control carried from front to back
  typedef struct packed {
    logic emit;    // previous frame is held, read one pixel out
    logic last;    // last source pixel of the frame
    logic wr_sel;  // store being written; the other one is read
  } rot_ctl_t;

  localparam int CTL_W = $bits(rot_ctl_t);

endpackage

// ----- sv/image_rotate_90.sv -----
// path: an accepted pixel beat waits in the queue; on leaving, its result beat (the
//   pixel of the previous frame at the same position) is read from a registered store
// throughput: one pixel per cycle while out_stall is low; the frame-store ram
//   ports and the two-entry queue between front and back allow a beat every clock
// reset: synchronous, active low; clears counters, queue and output valid,
//   dims to 256 or MAX_DIM if less; stores not cleared, first frame gives no output
module image_rotate_90 #(
  parameter int MAX_DIM    = rot90_pkg::DEF_MAX_DIM,
  parameter int PIXEL_BITS = rot90_pkg::DEF_PIXEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_write_en,
  input  logic [rot90_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rot90_pkg::CFG_W-1:0]     cfg_wdata,
  // source pixel stream
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [PIXEL_BITS-1:0]           in_pixel_in,
  // rotated pixel stream
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [PIXEL_BITS-1:0]           out_pixel_out,
  output logic                            out_frame_end
);

  localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int Q_W   = rot90_pkg::CTL_W + 2 * AW + PIXEL_BITS;

  // front to queue
  logic                  push;
  rot90_pkg::rot_ctl_t   push_ctl;
  logic [AW-1:0]         push_waddr;
  logic [AW-1:0]         push_raddr;
  logic [PIXEL_BITS-1:0] push_pixel;

  // queue to back
  logic                  q_full;
  logic                  q_empty;
  logic                  pop;
  logic [Q_W-1:0]        q_din;
  logic [Q_W-1:0]        q_dout;
  rot90_pkg::rot_ctl_t   q_ctl;
  logic [AW-1:0]         q_waddr;
  logic [AW-1:0]         q_raddr;
  logic [PIXEL_BITS-1:0] q_pixel;

  // front: config registers, raster position, rotated write address,
  // read index into the held frame and ping-pong selection
  rot_front #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel_in  (in_pixel_in),
    .q_full       (q_full),
    .push         (push),
    .push_ctl     (push_ctl),
    .push_waddr   (push_waddr),
    .push_raddr   (push_raddr),
    .push_pixel   (push_pixel)
  );

  // one queue entry per beat: control, write address, read address, pixel
  assign q_din = {push_ctl, push_waddr, push_raddr, push_pixel};
  assign {q_ctl, q_waddr, q_raddr, q_pixel} = q_dout;

  rot_fifo #(
    .WIDTH (Q_W),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // back: writes the active store, reads the other one, holds the result beat
  rot_back #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_ctl         (q_ctl),
    .q_waddr       (q_waddr),
    .q_raddr       (q_raddr),
    .q_pixel       (q_pixel),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

endmodule

// ----- sv/rot_ram.sv -----
module rot_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/rot_fifo.sv -----
module rot_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNTW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- sv/rot_front.sv -----
module rot_front #(
  parameter int MAX_DIM    = rot90_pkg::DEF_MAX_DIM,
  parameter int PIXEL_BITS = rot90_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write_en,
  input  logic [rot90_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rot90_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [PIXEL_BITS-1:0]               in_pixel_in,
  input  logic                                q_full,
  output logic                                push,
  output rot90_pkg::rot_ctl_t                 push_ctl,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  push_waddr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  push_raddr,
  output logic [PIXEL_BITS-1:0]               push_pixel
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(MAX_DIM);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int EW = (DW > rot90_pkg::CFG_W) ? DW : rot90_pkg::CFG_W;
  localparam int PW = 2 * DW;
  localparam int RST_DIM = (rot90_pkg::DIM_RESET < MAX_DIM) ? rot90_pkg::DIM_RESET : MAX_DIM;
  localparam int RD_MAX = MAX_DIM * MAX_DIM - 1;

  logic [DW-1:0] width_r, width_nxt;
  logic [DW-1:0] height_r, height_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic          act_r, act_nxt;
  logic          ready_r, ready_nxt;

  logic [EW-1:0] cfg_ext;
  logic [DW-1:0] cfg_dim;
  logic          col_last;
  logic          row_last;
  logic          last;
  logic [DW-1:0] col_rev;
  logic [PW-1:0] prod;

  // 0 acts as 1, anything above the maximum as the maximum
  always_comb begin
    cfg_ext = EW'(cfg_wdata);
    if (cfg_ext == '0) begin
      cfg_dim = DW'(1);
    end else if (cfg_ext > EW'(MAX_DIM)) begin
      cfg_dim = DW'(MAX_DIM);
    end else begin
      cfg_dim = DW'(cfg_ext);
    end
  end

  assign col_last = ((DW'(col_r) + DW'(1)) == width_r);
  assign row_last = ((DW'(row_r) + DW'(1)) == height_r);
  assign last     = col_last && row_last;

  // rotated address (w-1-col)*h + row
  assign col_rev = width_r - DW'(1) - DW'(col_r);
  assign prod    = PW'(col_rev) * PW'(height_r);

  assign in_stall   = q_full;
  assign push       = in_valid && !q_full;
  assign push_waddr = AW'(prod + PW'(row_r));
  assign push_raddr = rd_idx_r;
  assign push_pixel = in_pixel_in;

  always_comb begin
    push_ctl.emit   = ready_r;
    push_ctl.last   = last;
    push_ctl.wr_sel = act_r;
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    rd_idx_nxt = rd_idx_r;
    act_nxt    = act_r;
    ready_nxt  = ready_r;
    if (cfg_write_en) begin
      unique case (rot90_pkg::cfg_reg_t'(cfg_index))
        rot90_pkg::REG_FRAME_WIDTH:  width_nxt  = cfg_dim;
        rot90_pkg::REG_FRAME_HEIGHT: height_nxt = cfg_dim;
      endcase
      col_nxt    = '0;
      row_nxt    = '0;
      rd_idx_nxt = '0;
      ready_nxt  = 1'b0;
    end else if (push) begin
      if (last) begin
        col_nxt    = '0;
        row_nxt    = '0;
        rd_idx_nxt = '0;
        act_nxt    = !act_r;
        ready_nxt  = 1'b1;
      end else begin
        if (col_last) begin
          col_nxt = '0;
          row_nxt = row_r + CW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
        if (rd_idx_r != AW'(RD_MAX)) begin
          rd_idx_nxt = rd_idx_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(RST_DIM);
      height_r <= DW'(RST_DIM);
      col_r    <= '0;
      row_r    <= '0;
      rd_idx_r <= '0;
      act_r    <= 1'b0;
      ready_r  <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      rd_idx_r <= rd_idx_nxt;
      act_r    <= act_nxt;
      ready_r  <= ready_nxt;
    end
  end

endmodule

// ----- sv/rot_back.sv -----
module rot_back #(
  parameter int MAX_DIM    = rot90_pkg::DEF_MAX_DIM,
  parameter int PIXEL_BITS = rot90_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  rot90_pkg::rot_ctl_t                 q_ctl,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  q_waddr,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  q_raddr,
  input  logic [PIXEL_BITS-1:0]               q_pixel,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [PIXEL_BITS-1:0]               out_pixel_out,
  output logic                                out_frame_end
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_end_r;
  logic                  rd_sel_r;
  logic                  slot_free;
  logic                  rd_go;
  logic                  we0, we1, re0, re1;
  logic [PIXEL_BITS-1:0] rdata0, rdata1;

  // a reading beat only leaves the queue when the output slot frees up
  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = !q_empty && (!q_ctl.emit || slot_free);
  assign rd_go     = pop && q_ctl.emit;

  assign we0 = pop && !q_ctl.wr_sel;
  assign we1 = pop &&  q_ctl.wr_sel;
  assign re0 = rd_go &&  q_ctl.wr_sel;
  assign re1 = rd_go && !q_ctl.wr_sel;

  rot_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store0 (
    .clk   (clk),
    .we    (we0),
    .waddr (q_waddr),
    .wdata (q_pixel),
    .re    (re0),
    .raddr (q_raddr),
    .rdata (rdata0)
  );

  rot_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store1 (
    .clk   (clk),
    .we    (we1),
    .waddr (q_waddr),
    .wdata (q_pixel),
    .re    (re1),
    .raddr (q_raddr),
    .rdata (rdata1)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rd_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      out_end_r <= q_ctl.last;
      rd_sel_r  <= !q_ctl.wr_sel;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_frame_end = out_end_r;
  assign out_pixel_out = rd_sel_r ? rdata1 : rdata0;

endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W       = rot90_pkg::DEF_PIXEL_BITS;
  localparam int DIM_MAX     = rot90_pkg::DEF_MAX_DIM;
  localparam int STORE_DEPTH = rot90_pkg::DEF_MAX_DIM * rot90_pkg::DEF_MAX_DIM;
  localparam int REG_W       = rot90_pkg::CFG_W;
  localparam int IDX_W       = rot90_pkg::CFG_IDX_W;
  // cycles to let pass after the last result before touching the registers
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 260;

  // rotation predictor and queue of rotated beats still owed by the block
  class rotated_frame_sb;
    typedef struct {
      logic [PIX_W-1:0] pixel;
      logic             frame_end;
    } rot_beat_t;

    logic [PIX_W-1:0] frame_mem [2][STORE_DEPTH];
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;
    int unsigned      src_row;
    int unsigned      src_col;
    int unsigned      rd_addr;
    bit               wr_sel;
    bit               frame_held;
    int               errors;
    rot_beat_t        owed_beats[$];

    function new();
      width_reg  = REG_W'(rot90_pkg::DIM_RESET);
      height_reg = REG_W'(rot90_pkg::DIM_RESET);
      wr_sel     = 1'b0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      src_row    = 0;
      src_col    = 0;
      rd_addr    = 0;
      frame_held = 1'b0;
    endfunction

    // zero behaves as one, anything past the maximum dimension as the maximum
    function int unsigned clamp_dim(logic [REG_W-1:0] v);
      if (v < 1) return 1;
      if (v > DIM_MAX) return DIM_MAX;
      return 32'(v);
    endfunction

    function int unsigned frame_pixels();
      return clamp_dim(width_reg) * clamp_dim(height_reg);
    endfunction

    function void set_reg(rot90_pkg::cfg_reg_t idx, logic [REG_W-1:0] v);
      if (idx == rot90_pkg::REG_FRAME_WIDTH) width_reg = v;
      else height_reg = v;
      restart();
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      bit          last;
      rot_beat_t   beat;
      w    = clamp_dim(width_reg);
      h    = clamp_dim(height_reg);
      col  = (src_col < w) ? src_col : w - 1;
      row  = (src_row < h) ? src_row : h - 1;
      last = (row + 1 >= h) && (col + 1 >= w);
      if (frame_held) begin
        beat.pixel     = frame_mem[wr_sel ^ 1'b1][rd_addr];
        beat.frame_end = last;
        owed_beats.push_back(beat);
      end
      frame_mem[wr_sel][(w - 1 - col) * h + row] = pix;
      if (last) begin
        src_row    = 0;
        src_col    = 0;
        rd_addr    = 0;
        wr_sel     = wr_sel ^ 1'b1;
        frame_held = 1'b1;
      end else begin
        if (col + 1 >= w) begin
          src_col = 0;
          src_row = row + 1;
        end else begin
          src_col = col + 1;
          src_row = row;
        end
        if (rd_addr + 1 < STORE_DEPTH) rd_addr = rd_addr + 1;
      end
    endfunction

    function void check_beat(logic [PIX_W-1:0] pix, logic fend);
      rot_beat_t beat;
      if (owed_beats.size() == 0) begin
        $display("%0t: unexpected beat pixel_out %06h frame_end %0b", $time, pix, fend);
        errors++;
        return;
      end
      beat = owed_beats.pop_front();
      if (pix !== beat.pixel) begin
        $display("%0t: pixel_out expected %06h actual %06h", $time, beat.pixel, pix);
        errors++;
      end
      if (fend !== beat.frame_end) begin
        $display("%0t: frame_end expected %0b actual %0b", $time, beat.frame_end, fend);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_write_en;
  logic [IDX_W-1:0]  cfg_index;
  logic [REG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [PIX_W-1:0]  in_pixel_in;
  logic              out_valid;
  logic              out_stall;
  logic [PIX_W-1:0]  out_pixel_out;
  logic              out_frame_end;

  rotated_frame_sb rot_sb = new();

  // beats left in the current sender burst
  int burst_left = 0;
  int random_sent = 0;

  image_rotate_90 i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

  // receiver: stall pattern changes mode every run of cycles
  initial begin
    int mode;
    int run;
    int k;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(10, 150);
      for (k = 0; k < run; k++) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 2) == 0);
          end
          2: begin
            // periodic stall, repeating with the loop index
            out_stall <= ((k % 8) < 3);
          end
          default: begin
            out_stall <= 1'($urandom_range(0, 1));
          end
        endcase
      end
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) rot_sb.check_beat(out_pixel_out, out_frame_end);
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  // one source pixel beat; gaps are inserted between bursts
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_pixel_in <= pix;
    do @(posedge clk); while (in_stall);
    rot_sb.note_pixel(pix);
    burst_left--;
  endtask

  // stop sending and wait until every owed beat is out
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rot_sb.owed_beats.size() != 0) @(posedge clk);
    // a beat of the first frame gives no result, let the pipe empty anyway
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input rot90_pkg::cfg_reg_t idx, input logic [REG_W-1:0] v);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_wdata    <= v;
    @(posedge clk);
    rot_sb.set_reg(idx, v);
  endtask

  // both registers, in random order; either write restarts the frame
  task automatic set_dims(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
    if ($urandom_range(0, 1)) begin
      write_reg(rot90_pkg::REG_FRAME_WIDTH, w);
      write_reg(rot90_pkg::REG_FRAME_HEIGHT, h);
    end else begin
      write_reg(rot90_pkg::REG_FRAME_HEIGHT, h);
      write_reg(rot90_pkg::REG_FRAME_WIDTH, w);
    end
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // full frames of random pixels, then a partial frame cut off by the next write
  task automatic run_frames(input int full, input int partial);
    int n;
    int k;
    n = full * rot_sb.frame_pixels() + partial;
    for (k = 0; k < n; k++) send_pixel(rand_pixel());
  endtask

  initial begin
    int pick;
    int full;
    int partial;
    int fsize;
    logic [REG_W-1:0] w;
    logic [REG_W-1:0] h;
    int k;

    rst_n        = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index    = rot90_pkg::REG_FRAME_WIDTH;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_pixel_in  = '0;
    out_stall    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero dims act as 1x1: every beat closes a frame, the first gives nothing
    set_dims(9'd0, 9'd0);
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'haaaaaa);
    send_pixel(24'h555555);
    send_pixel(24'h123456);
    drain_block();

    // 3x2: two full frames, then a partial third restarted by the next write
    set_dims(9'd3, 9'd2);
    for (k = 0; k < 15; k++) send_pixel(PIX_W'(k * 'h111111));
    drain_block();

    // widest row or tallest column past the clamp, one frame plus the head
    // of the next
    if ($urandom_range(0, 1)) begin
      set_dims(9'd511, 9'd1);
    end else begin
      set_dims(9'd1, 9'd300);
    end
    run_frames(1, 16);
    drain_block();

    // random geometry phases, mostly small frames
    while (random_sent < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 18);
      if (pick < 14) begin
        w = REG_W'($urandom_range(1, 6));
        h = REG_W'($urandom_range(1, 6));
      end else if (pick < 16) begin
        w = REG_W'($urandom_range(1, 16));
        h = REG_W'($urandom_range(1, 16));
      end else begin
        // one dimension zero, or both
        w = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(1, 5));
        h = (w == 0) ? 9'($urandom_range(0, 5)) : 9'd0;
      end
      set_dims(w, h);
      fsize = rot_sb.frame_pixels();
      full  = (fsize > 64) ? 1 : $urandom_range(2, 4);
      // broken sequences: a frame cut short before the next write
      partial = (fsize > 1 && $urandom_range(0, 1)) ? $urandom_range(1, fsize - 1) : 0;
      if (partial > 30) partial = $urandom_range(1, 30);
      run_frames(full, partial);
      random_sent += full * fsize + partial;
      drain_block();
    end

    drain_block();
    if (rot_sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
